// ===== rtl/core/cmap4_pkg.sv =====
// ----------------------------------------------------------------------------
// cmap4_pkg
// shared constants, codes and types of the cmap format 4 glyph lookup core
// ----------------------------------------------------------------------------
package cmap4_pkg;

   // store depths
   localparam int MAX_SEGMENTS      = 256;
   localparam int GLYPH_ARRAY_DEPTH = 4096;

   // derived widths
   localparam int SEG_IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int SEG_CNT_W = SEG_IDX_W + 1;
   localparam int ARR_IDX_W = (GLYPH_ARRAY_DEPTH > 1) ? $clog2(GLYPH_ARRAY_DEPTH) : 1;

   // fixed field widths
   localparam int CODE_W       = 16;
   localparam int CODEPOINT_W  = 21;
   localparam int SEG_COUNT_W  = 9;
   localparam int ARR_COUNT_W  = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;
   // signed glyph array index: ro/2 + (code - start) - (count - mid)
   localparam int IDX_W        = 18;

   // item op codes
   localparam logic [1:0] OP_WRITE_SEG  = 2'd0;
   localparam logic [1:0] OP_WRITE_WORD = 2'd1;
   localparam logic [1:0] OP_LOOKUP     = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_COUNT     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_ARRAY_COUNT = 1'd1;

   typedef struct packed {
      logic [CODE_W-1:0] end_code;
      logic [CODE_W-1:0] start_code;
      logic [CODE_W-1:0] id_delta;
      logic [CODE_W-1:0] range_offset;
   } seg_entry_type;

   // read requests from the lookup sequencer to the two memories
   typedef struct packed {
      logic                 seg_rd_en;
      logic [SEG_IDX_W-1:0] seg_rd_addr;
      logic                 arr_rd_en;
      logic [ARR_IDX_W-1:0] arr_rd_addr;
   } mem_rd_req_type;

endpackage

// ===== rtl/core/cmap4_ram.sv =====
// ----------------------------------------------------------------------------
// cmap4_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cmap4_ram #(
   parameter int  WIDTH  = 16,
   parameter int  DEPTH  = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/cmap4_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmap4_ctrl
// lookup sequencer: binary search over the segment ram, glyph array fetch
// ----------------------------------------------------------------------------
module cmap4_ctrl (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   lookup_go,
   input  logic [cmap4_pkg::CODEPOINT_W-1:0]      codepoint,
   input  logic [cmap4_pkg::SEG_COUNT_W-1:0]      seg_count,
   input  logic [cmap4_pkg::ARR_COUNT_W-1:0]      arr_count,
   input  cmap4_pkg::seg_entry_type               seg_rd_data,
   input  logic [cmap4_pkg::CODE_W-1:0]           arr_rd_data,
   output cmap4_pkg::mem_rd_req_type              rd_req,
   output logic                                   busy,
   output logic                                   rsp_valid,
   output logic [cmap4_pkg::CODE_W-1:0]           rsp_glyph_id
);

   localparam int SEG_IDX_W = cmap4_pkg::SEG_IDX_W;
   localparam int SEG_CNT_W = cmap4_pkg::SEG_CNT_W;
   localparam int ARR_IDX_W = cmap4_pkg::ARR_IDX_W;
   localparam int CODE_W    = cmap4_pkg::CODE_W;
   localparam int IDX_W     = cmap4_pkg::IDX_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_CALC   = 2'd2;
   localparam logic [1:0] ST_FETCH  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [SEG_CNT_W-1:0] lo_ff, lo_in;
   logic [SEG_IDX_W-1:0] hi_ff, hi_in;
   logic [SEG_IDX_W-1:0] mid_ff, mid_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic [CODE_W-1:0]    start_ff, start_in;
   logic [CODE_W-1:0]    delta_ff, delta_in;
   logic [CODE_W-1:0]    ro_ff, ro_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]    rsp_glyph_ff, rsp_glyph_in;

   logic [SEG_CNT_W-1:0] cnt_eff;
   logic [SEG_IDX_W-1:0] init_hi;
   logic                 early_zero;
   logic                 go_up;
   logic                 go_down;
   logic                 found;
   logic [SEG_CNT_W-1:0] lo_nx;
   logic [SEG_IDX_W-1:0] hi_nx;
   logic                 empty;
   logic [SEG_CNT_W-1:0] mid_sum;
   logic [IDX_W-1:0]     arr_idx;
   logic                 idx_ok;

   // segment count clamped to the store depth
   always_comb begin
      if (32'(seg_count) > 32'(cmap4_pkg::MAX_SEGMENTS)) begin
         cnt_eff = SEG_CNT_W'(cmap4_pkg::MAX_SEGMENTS);
      end else begin
         cnt_eff = SEG_CNT_W'(seg_count);
      end
   end

   assign init_hi    = SEG_IDX_W'(cnt_eff - SEG_CNT_W'(1));
   assign early_zero = (|codepoint[cmap4_pkg::CODEPOINT_W-1:CODE_W]) || (cnt_eff == '0);

   // one probe step on the entry read in the previous cycle
   assign go_up   = code_ff > seg_rd_data.end_code;
   assign go_down = !go_up && (mid_ff != '0) && (code_ff < seg_rd_data.start_code);
   assign found   = !go_up && !go_down;
   assign lo_nx   = go_up ? (SEG_CNT_W'(mid_ff) + SEG_CNT_W'(1)) : lo_ff;
   assign hi_nx   = go_down ? (mid_ff - SEG_IDX_W'(1)) : hi_ff;
   assign empty   = lo_nx > SEG_CNT_W'(hi_nx);
   assign mid_sum = lo_nx + SEG_CNT_W'(hi_nx);

   // glyph array index, code is known to be at or above start here
   assign arr_idx = IDX_W'(ro_ff[CODE_W-1:1]) + IDX_W'(code_ff - start_ff)
                  - IDX_W'(cnt_eff) + IDX_W'(mid_ff);
   assign idx_ok  = !arr_idx[IDX_W-1]
                  && (arr_idx < IDX_W'(arr_count))
                  && (32'(arr_idx) < 32'(cmap4_pkg::GLYPH_ARRAY_DEPTH));

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      code_in      = code_ff;
      start_in     = start_ff;
      delta_in     = delta_ff;
      ro_in        = ro_ff;
      rsp_valid_in = 1'b0;
      rsp_glyph_in = rsp_glyph_ff;
      rd_req       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (lookup_go) begin
               code_in = codepoint[CODE_W-1:0];
               if (early_zero) begin
                  rsp_valid_in = 1'b1;
                  rsp_glyph_in = '0;
               end else begin
                  lo_in              = '0;
                  hi_in              = init_hi;
                  mid_in             = init_hi >> 1;
                  rd_req.seg_rd_en   = 1'b1;
                  rd_req.seg_rd_addr = init_hi >> 1;
                  state_in           = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (found) begin
               start_in = seg_rd_data.start_code;
               delta_in = seg_rd_data.id_delta;
               ro_in    = seg_rd_data.range_offset;
               if (code_ff < seg_rd_data.start_code) begin
                  rsp_valid_in = 1'b1;
                  rsp_glyph_in = '0;
                  state_in     = ST_IDLE;
               end else if (seg_rd_data.range_offset == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_glyph_in = code_ff + seg_rd_data.id_delta;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_CALC;
               end
            end else if (empty) begin
               rsp_valid_in = 1'b1;
               rsp_glyph_in = '0;
               state_in     = ST_IDLE;
            end else begin
               lo_in              = lo_nx;
               hi_in              = hi_nx;
               mid_in             = mid_sum[SEG_CNT_W-1:1];
               rd_req.seg_rd_en   = 1'b1;
               rd_req.seg_rd_addr = mid_sum[SEG_CNT_W-1:1];
            end
         end
         ST_CALC: begin
            if (idx_ok) begin
               rd_req.arr_rd_en   = 1'b1;
               rd_req.arr_rd_addr = arr_idx[ARR_IDX_W-1:0];
               state_in           = ST_FETCH;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_glyph_in = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_FETCH: begin
            rsp_valid_in = 1'b1;
            rsp_glyph_in = (arr_rd_data == '0) ? '0 : (arr_rd_data + delta_ff);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      code_ff      <= code_in;
      start_ff     <= start_in;
      delta_ff     <= delta_in;
      ro_ff        <= ro_in;
      rsp_glyph_ff <= rsp_glyph_in;
   end

   assign busy         = state_ff != ST_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_glyph_id = rsp_glyph_ff;

endmodule

// ===== rtl/core/cmap_format4_glyph_lookup_core.sv =====
// ----------------------------------------------------------------------------
// cmap_format4_glyph_lookup_core
// character code to glyph index lookup over a cmap format 4 segment table
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  request  | start, busy, req_op .. req_codepoint    | taken when start && !busy
//  result   | rsp_valid, rsp_glyph_id                 | one-cycle strobe, no stall
//  csr      | csr_wr_en, csr_index, csr_wr_data       | written when csr_wr_en
//
//  segment and glyph word writes leave busy low and give no result
//  a lookup runs p segment probes (1 to 9 for 256 segments), then reads the
//  glyph array when the segment has a range offset and the index is valid;
//  the bound is the segment ram, one probe per cycle with a registered read
//  lookups of codes above 0xffff or with no segments give 0 in the next cycle
//  reset clears the count registers and the sequencer, ram contents stay
//  the result side cannot stall; busy holds off new items during a search
//
module cmap_format4_glyph_lookup_core (
   input  logic        clock,
   input  logic        reset,
   // request items
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_segment_index,
   input  logic [15:0] req_end_code,
   input  logic [15:0] req_start_code,
   input  logic [15:0] req_id_delta,
   input  logic [15:0] req_range_offset,
   input  logic [11:0] req_array_index,
   input  logic [15:0] req_array_word,
   input  logic [20:0] req_codepoint,
   // result items
   output logic        rsp_valid,
   output logic [15:0] rsp_glyph_id,
   // register writes
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_wr_data
);

   localparam int SEG_IDX_W   = cmap4_pkg::SEG_IDX_W;
   localparam int ARR_IDX_W   = cmap4_pkg::ARR_IDX_W;
   localparam int SEG_COUNT_W = cmap4_pkg::SEG_COUNT_W;
   localparam int ARR_COUNT_W = cmap4_pkg::ARR_COUNT_W;

   // count registers
   logic [SEG_COUNT_W-1:0] seg_count_ff, seg_count_in;
   logic [ARR_COUNT_W-1:0] arr_count_ff, arr_count_in;

   // write side of the two stores
   logic                     item_take;
   logic                     seg_wr_en;
   logic [SEG_IDX_W-1:0]     seg_wr_addr;
   cmap4_pkg::seg_entry_type seg_wr_data;
   logic                     arr_wr_en;
   logic [ARR_IDX_W-1:0]     arr_wr_addr;

   // read side, driven by the sequencer
   cmap4_pkg::mem_rd_req_type rd_req;
   cmap4_pkg::seg_entry_type  seg_rd_data;
   logic [15:0]               arr_rd_data;
   logic                      lookup_go;

   assign item_take = start && !busy;
   assign lookup_go = item_take && (req_op == cmap4_pkg::OP_LOOKUP);

   // writes to slots beyond the store depth are dropped
   assign seg_wr_en   = item_take && (req_op == cmap4_pkg::OP_WRITE_SEG)
                      && (32'(req_segment_index) < 32'(cmap4_pkg::MAX_SEGMENTS));
   assign seg_wr_addr = SEG_IDX_W'(req_segment_index);
   assign arr_wr_en   = item_take && (req_op == cmap4_pkg::OP_WRITE_WORD)
                      && (32'(req_array_index) < 32'(cmap4_pkg::GLYPH_ARRAY_DEPTH));
   assign arr_wr_addr = ARR_IDX_W'(req_array_index);

   always_comb begin
      seg_wr_data.end_code     = req_end_code;
      seg_wr_data.start_code   = req_start_code;
      seg_wr_data.id_delta     = req_id_delta;
      seg_wr_data.range_offset = req_range_offset;
   end

   // register file, unknown indexes are ignored
   always_comb begin
      seg_count_in = seg_count_ff;
      arr_count_in = arr_count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            cmap4_pkg::CSR_SEGMENT_COUNT: begin
               seg_count_in = csr_wr_data[SEG_COUNT_W-1:0];
            end
            cmap4_pkg::CSR_GLYPH_ARRAY_COUNT: begin
               arr_count_in = csr_wr_data[ARR_COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= '0;
         arr_count_ff <= '0;
      end else begin
         seg_count_ff <= seg_count_in;
         arr_count_ff <= arr_count_in;
      end
   end

   // segment store: end, start, delta and range offset in one word
   cmap4_ram #(
      .WIDTH ($bits(cmap4_pkg::seg_entry_type)),
      .DEPTH (cmap4_pkg::MAX_SEGMENTS)
   ) u_seg_ram (
      .clock   (clock),
      .wr_en   (seg_wr_en),
      .wr_addr (seg_wr_addr),
      .wr_data (seg_wr_data),
      .rd_en   (rd_req.seg_rd_en),
      .rd_addr (rd_req.seg_rd_addr),
      .rd_data (seg_rd_data)
   );

   // glyph index array
   cmap4_ram #(
      .WIDTH (16),
      .DEPTH (cmap4_pkg::GLYPH_ARRAY_DEPTH)
   ) u_arr_ram (
      .clock   (clock),
      .wr_en   (arr_wr_en),
      .wr_addr (arr_wr_addr),
      .wr_data (req_array_word),
      .rd_en   (rd_req.arr_rd_en),
      .rd_addr (rd_req.arr_rd_addr),
      .rd_data (arr_rd_data)
   );

   // search and fetch sequencer, owns the result register
   cmap4_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .lookup_go    (lookup_go),
      .codepoint    (req_codepoint),
      .seg_count    (seg_count_ff),
      .arr_count    (arr_count_ff),
      .seg_rd_data  (seg_rd_data),
      .arr_rd_data  (arr_rd_data),
      .rd_req       (rd_req),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_glyph_id (rsp_glyph_id)
   );

   // a search that ends always leaves a result behind
   a_search_ends_in_result: assert property (
      @(posedge clock) disable iff (reset) $fell(busy) |-> rsp_valid
   ) else $error("lookup finished without a result strobe");

   // store writes never overlap a running search
   a_no_write_while_busy: assert property (
      @(posedge clock) disable iff (reset) busy |-> !seg_wr_en && !arr_wr_en
   ) else $error("store write during a lookup");

   // probes stay inside the valid segments
   a_seg_probe_in_range: assert property (
      @(posedge clock) disable iff (reset)
      rd_req.seg_rd_en |-> (32'(rd_req.seg_rd_addr) < 32'(seg_count_ff))
   ) else $error("segment probe beyond segment count");

   // glyph array reads stay inside the valid words
   a_arr_read_in_range: assert property (
      @(posedge clock) disable iff (reset)
      rd_req.arr_rd_en |-> (32'(rd_req.arr_rd_addr) < 32'(arr_count_ff))
   ) else $error("glyph array read beyond word count");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the cmap format 4 glyph lookup core: a directed
// table of items, then phases of sorted segment tables with random lookups,
// all results compared in order against a behavioral copy of the lookup or
// against a hand-typed glyph
module tb_top;

   // op 3 has no function in the core, it must be swallowed without a result
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int ITEMS_TARGET  = 1300;
   localparam int SETTLE_CYCLES = 16;     // outlasts the worst lookup of 9 probes and a glyph array read
   localparam int STALL_LIMIT   = 2000;   // cycles with nothing accepted
   localparam int DIR_ROWS      = 24;

   // one item as driven on the request ports
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  seg_slot;
      logic [15:0] end_code;
      logic [15:0] start_code;
      logic [15:0] id_delta;
      logic [15:0] range_offset;
      logic [11:0] word_slot;
      logic [15:0] word_val;
      logic [20:0] codepoint;
   } glyph_req_type;

   // one row of the directed table: a register write or an item, with an
   // optional hand-typed glyph where it is obvious from the spec
   typedef struct packed {
      logic          is_csr;
      logic [0:0]    reg_idx;
      logic [12:0]   reg_val;
      glyph_req_type req;
      logic          typed;
      logic [15:0]   glyph;
   } dir_row_type;

   logic        clock;
   logic        reset        = 1'b1;
   logic        start        = 1'b0;
   logic        busy;
   logic [1:0]  req_op            = '0;
   logic [7:0]  req_segment_index = '0;
   logic [15:0] req_end_code      = '0;
   logic [15:0] req_start_code    = '0;
   logic [15:0] req_id_delta      = '0;
   logic [15:0] req_range_offset  = '0;
   logic [11:0] req_array_index   = '0;
   logic [15:0] req_array_word    = '0;
   logic [20:0] req_codepoint     = '0;
   logic        rsp_valid;
   logic [15:0] rsp_glyph_id;
   logic        csr_wr_en   = 1'b0;
   logic [0:0]  csr_index   = '0;
   logic [12:0] csr_wr_data = '0;

   cmap_format4_glyph_lookup_core DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_segment_index (req_segment_index),
      .req_end_code      (req_end_code),
      .req_start_code    (req_start_code),
      .req_id_delta      (req_id_delta),
      .req_range_offset  (req_range_offset),
      .req_array_index   (req_array_index),
      .req_array_word    (req_array_word),
      .req_codepoint     (req_codepoint),
      .rsp_valid         (rsp_valid),
      .rsp_glyph_id      (rsp_glyph_id),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   // mirror of the mapping table and the count registers
   logic [15:0] tbl_end    [cmap4_pkg::MAX_SEGMENTS];
   logic [15:0] tbl_start  [cmap4_pkg::MAX_SEGMENTS];
   logic [15:0] tbl_delta  [cmap4_pkg::MAX_SEGMENTS];
   logic [15:0] tbl_offset [cmap4_pkg::MAX_SEGMENTS];
   logic [15:0] tbl_word   [cmap4_pkg::GLYPH_ARRAY_DEPTH];
   bit          word_set   [cmap4_pkg::GLYPH_ARRAY_DEPTH];
   logic [8:0]  cnt_segments = '0;
   logic [12:0] cnt_words    = '0;

   logic [15:0] pending_glyphs [$];   // expected glyph ids, oldest first
   dir_row_type dir_table [DIR_ROWS];
   int          n_fail       = 0;
   int          n_items      = 0;
   int          stall_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // glyph mapping: binary search over segments sorted by end code
   // arr_read/arr_idx tell whether and where the glyph array gets read
   // ---------------------------------------------------------------------
   function automatic void map_codepoint(input logic [20:0] cp, output logic [15:0] glyph,
                                         output bit arr_read, output int arr_idx);
      int cnt, lo, hi, mid, code, s, e, d, ro, idx;
      glyph    = '0;
      arr_read = 0;
      arr_idx  = 0;
      cnt      = int'(cnt_segments);
      // a count beyond the store depth is clamped, also in the index math
      if (cnt > cmap4_pkg::MAX_SEGMENTS) cnt = cmap4_pkg::MAX_SEGMENTS;
      code = int'(cp);
      // empty table and codes past the basic plane map to the missing glyph
      if (cnt == 0 || code > 'hFFFF) return;
      lo = 0;
      hi = cnt - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         e   = int'(tbl_end[mid]);
         s   = int'(tbl_start[mid]);
         if (code > e) begin
            lo = mid + 1;
         end else if (mid > 0 && code < s) begin
            hi = mid - 1;
         end else begin
            // segment 0 is taken even below its start, which maps to 0
            if (code < s) return;
            d  = int'(tbl_delta[mid]);
            ro = int'(tbl_offset[mid]);
            if (ro == 0) begin
               glyph = 16'(code + d);
               return;
            end
            idx = ro / 2 + (code - s) - (cnt - mid);
            if (idx < 0 || idx >= int'(cnt_words) ||
                idx >= cmap4_pkg::GLYPH_ARRAY_DEPTH) return;
            arr_read = 1;
            arr_idx  = idx;
            // a zero word is the missing glyph, the delta is not applied
            if (tbl_word[idx] == '0) return;
            glyph = 16'(int'(tbl_word[idx]) + d);
            return;
         end
      end
   endfunction

   // all fields random, so idle fields also toggle every bit
   function automatic glyph_req_type rand_item();
      glyph_req_type it;
      it.op           = 2'($urandom);
      it.seg_slot     = 8'($urandom);
      it.end_code     = 16'($urandom);
      it.start_code   = 16'($urandom);
      it.id_delta     = 16'($urandom);
      it.range_offset = 16'($urandom);
      it.word_slot    = 12'($urandom);
      it.word_val     = 16'($urandom);
      it.codepoint    = 21'($urandom);
      return it;
   endfunction

   // directed table rows
   function automatic dir_row_type row_op(input logic [1:0] op);
      dir_row_type r;
      r        = '0;
      r.req.op = op;
      return r;
   endfunction

   function automatic dir_row_type row_register(input logic [0:0] idx,
                                                input logic [12:0] val);
      dir_row_type r;
      r         = '0;
      r.is_csr  = 1'b1;
      r.reg_idx = idx;
      r.reg_val = val;
      return r;
   endfunction

   function automatic dir_row_type row_segment(input logic [7:0] slot, input logic [15:0] e,
                                               input logic [15:0] s, input logic [15:0] d,
                                               input logic [15:0] ro);
      dir_row_type r;
      r                  = row_op(cmap4_pkg::OP_WRITE_SEG);
      r.req.seg_slot     = slot;
      r.req.end_code     = e;
      r.req.start_code   = s;
      r.req.id_delta     = d;
      r.req.range_offset = ro;
      return r;
   endfunction

   function automatic dir_row_type row_word(input logic [11:0] slot, input logic [15:0] w);
      dir_row_type r;
      r              = row_op(cmap4_pkg::OP_WRITE_WORD);
      r.req.word_slot = slot;
      r.req.word_val  = w;
      return r;
   endfunction

   function automatic dir_row_type row_lookup(input logic [20:0] cp, input logic typed,
                                              input logic [15:0] g);
      dir_row_type r;
      r               = row_op(cmap4_pkg::OP_LOOKUP);
      r.req.codepoint = cp;
      r.typed         = typed;
      r.glyph         = g;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // request driver: fields change at the falling edge, the item is taken
   // at the rising edge with start high and busy low
   // ---------------------------------------------------------------------
   task automatic send_item(input glyph_req_type it, input logic typed,
                            input logic [15:0] typed_glyph);
      logic [15:0] g;
      bit          rd;
      int          ix;
      @(negedge clock);
      req_op            = it.op;
      req_segment_index = it.seg_slot;
      req_end_code      = it.end_code;
      req_start_code    = it.start_code;
      req_id_delta      = it.id_delta;
      req_range_offset  = it.range_offset;
      req_array_index   = it.word_slot;
      req_array_word    = it.word_val;
      req_codepoint     = it.codepoint;
      start             = 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      n_items++;
      // item accepted, update the mirror in the same order as the core
      case (it.op)
         cmap4_pkg::OP_WRITE_SEG: begin
            tbl_end[it.seg_slot]    = it.end_code;
            tbl_start[it.seg_slot]  = it.start_code;
            tbl_delta[it.seg_slot]  = it.id_delta;
            tbl_offset[it.seg_slot] = it.range_offset;
         end
         cmap4_pkg::OP_WRITE_WORD: begin
            tbl_word[it.word_slot] = it.word_val;
            word_set[it.word_slot] = 1;
         end
         cmap4_pkg::OP_LOOKUP: begin
            map_codepoint(it.codepoint, g, rd, ix);
            pending_glyphs.insert(pending_glyphs.size(), typed ? typed_glyph : g);
         end
         default: ;
      endcase
   endtask

   // idle burst with start low, taken with the given percent chance
   task automatic maybe_gap(input int gap_pct);
      int n;
      if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
         n = $urandom_range(1, 11);
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // stop sending, wait out every outstanding lookup and let the core settle
   task automatic drain_lookups();
      @(negedge clock);
      start = 1'b0;
      while (pending_glyphs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [12:0] val);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == cmap4_pkg::CSR_SEGMENT_COUNT) cnt_segments = val[8:0];
      else cnt_words = val;
   endtask

   // ---------------------------------------------------------------------
   // one phase: set the counts, build a sorted segment table, then a mix
   // of lookups with some table rewrites and unused ops as noise
   // ---------------------------------------------------------------------
   task automatic run_phase(input logic [8:0] nseg, input logic [12:0] nwords, input int gap_pct);
      int            eff, arr_eff, span, k, s, e, ro, lim, code, r, n, ix;
      glyph_req_type it, fill;
      logic [15:0]   g;
      bit            rd;
      drain_lookups();
      // unused upper data bits on the segment count write are dropped
      write_reg(cmap4_pkg::CSR_SEGMENT_COUNT, {4'($urandom), nseg});
      write_reg(cmap4_pkg::CSR_GLYPH_ARRAY_COUNT, nwords);
      eff     = (nseg > cmap4_pkg::MAX_SEGMENTS) ? cmap4_pkg::MAX_SEGMENTS : int'(nseg);
      arr_eff = (nwords > cmap4_pkg::GLYPH_ARRAY_DEPTH) ? cmap4_pkg::GLYPH_ARRAY_DEPTH
                                                       : int'(nwords);

      // well-formed table: every searched slot written, end codes ascending
      if (eff > 0) span = 65536 / eff;
      for (k = 0; k < eff; k++) begin
         s = k * span + $urandom_range(0, span / 4);
         e = s + $urandom_range(0, span / 2 - 1);
         if ($urandom_range(0, 7) == 0) e = s;
         if (k == eff - 1 && $urandom_range(0, 1) == 1) e = 'hFFFF;
         // offsets aimed so codes near the segment start land in the array
         case ($urandom_range(0, 9))
            0, 1, 2, 3: ro = 0;
            9:          ro = int'(16'($urandom));
            default:    ro = 2 * ($urandom_range(0, (arr_eff > 0) ? arr_eff : 16) + eff - k)
                             + $urandom_range(0, 1);
         endcase
         it              = rand_item();
         it.op           = cmap4_pkg::OP_WRITE_SEG;
         it.seg_slot     = 8'(k);
         it.end_code     = 16'(e);
         it.start_code   = 16'(s);
         it.range_offset = 16'(ro);
         maybe_gap(gap_pct);
         send_item(it, 1'b0, '0);
      end

      n = $urandom_range(80, 160);
      repeat (n) begin
         it = rand_item();
         r  = $urandom_range(0, 99);
         if (r < 10) begin
            // glyph word rewrite, zero words included
            it.op = cmap4_pkg::OP_WRITE_WORD;
            if (arr_eff > 0 && $urandom_range(0, 2) != 0)
               it.word_slot = 12'($urandom_range(0, arr_eff - 1));
            if ($urandom_range(0, 5) == 0) it.word_val = '0;
         end else if (r < 18) begin
            // segment rewrite: a quarter keep the codes of a live slot, the rest are plain noise
            it.op = cmap4_pkg::OP_WRITE_SEG;
            if (eff > 0 && $urandom_range(0, 1) == 1) begin
               it.seg_slot = 8'($urandom_range(0, eff - 1));
               if ($urandom_range(0, 1) == 1) begin
                  it.end_code   = tbl_end[it.seg_slot];
                  it.start_code = tbl_start[it.seg_slot];
               end
            end
         end else if (r < 22) begin
            it.op = OP_UNUSED;
         end else begin
            it.op = cmap4_pkg::OP_LOOKUP;
            k     = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
            s     = int'(tbl_start[k]);
            e     = int'(tbl_end[k]);
            r     = $urandom_range(0, 99);
            if (eff > 0 && r < 60) begin
               lim = e - s;
               if (lim < 0) lim = 0;
               if (lim > 48) lim = 48;
               code = s + $urandom_range(0, lim);
            end else if (eff > 0 && r < 72) begin
               // segment edges and the codes just outside them
               case ($urandom_range(0, 3))
                  0:       code = s;
                  1:       code = e;
                  2:       code = (s - 1) & 'hFFFF;
                  default: code = (e + 1) & 'hFFFF;
               endcase
            end else if (r < 88) begin
               code = $urandom_range(0, 'hFFFF);
            end else begin
               code = $urandom_range('h10000, 'h1FFFFF);
            end
            it.codepoint = 21'(code);
            // a glyph word the lookup would read must exist first
            map_codepoint(it.codepoint, g, rd, ix);
            if (rd && !word_set[ix]) begin
               fill           = rand_item();
               fill.op        = cmap4_pkg::OP_WRITE_WORD;
               fill.word_slot = 12'(ix);
               fill.word_val  = ($urandom_range(0, 6) == 0) ? 16'd0 : 16'($urandom);
               maybe_gap(gap_pct);
               send_item(fill, 1'b0, '0);
            end
         end
         maybe_gap(gap_pct);
         send_item(it, 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------------
   // result checker: every strobe pops the oldest expected glyph
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_glyphs.size() == 0) begin
            n_fail++;
            $display("%0t: result with no lookup pending, expected none, actual %h",
                     $time, rsp_glyph_id);
         end else begin
            want = pending_glyphs.pop_front();
            if (rsp_glyph_id !== want) begin
               n_fail++;
               $display("%0t: glyph_id mismatch, expected %h, actual %h",
                        $time, want, rsp_glyph_id);
            end
         end
      end
   end

   // watchdog: nothing taken on either side for too long means a hang
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("** cmap_format4_glyph_lookup_core: FAILED **");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      glyph_req_type it;
      logic [8:0]    nseg;
      logic [12:0]   nwords;
      int            gap;

      // three segments: a delta-only range with a negative delta, a range
      // through the glyph array, and the closing 0xffff segment
      dir_table = '{
         row_lookup(21'h41, 1'b1, 16'h0000),          // empty table after reset
         row_register(cmap4_pkg::CSR_SEGMENT_COUNT, 13'd3),
         row_register(cmap4_pkg::CSR_GLYPH_ARRAY_COUNT, 13'd8),
         row_segment(8'd0, 16'h007F, 16'h0020, 16'hFFE3, 16'd0),
         row_segment(8'd1, 16'h00FF, 16'h00A0, 16'h0000, 16'd4),
         row_segment(8'd2, 16'hFFFF, 16'hFFFF, 16'h0001, 16'd0),
         row_word(12'd0, 16'h0010),
         row_word(12'd1, 16'h0000),
         row_word(12'd2, 16'hFFFF),
         row_lookup(21'h41, 1'b1, 16'h0024),          // delta wraps past 0xffff
         row_lookup(21'h0, 1'b1, 16'h0000),           // below the first segment start
         row_lookup(21'h10000, 1'b1, 16'h0000),       // just past the basic plane
         row_lookup(21'h1FFFFF, 1'b1, 16'h0000),      // largest code point
         row_lookup(21'hFFFF, 1'b1, 16'h0000),        // 0xffff + 1 wraps to 0
         row_lookup(21'hA0, 1'b0, 16'h0000),
         row_lookup(21'hA1, 1'b1, 16'h0000),          // zero glyph word
         row_lookup(21'hA2, 1'b0, 16'h0000),
         row_lookup(21'hA8, 1'b1, 16'h0000),          // index past the array count
         row_lookup(21'h90, 1'b1, 16'h0000),          // gap between segments
         row_op(OP_UNUSED),
         row_segment(8'd1, 16'h00FF, 16'h00A0, 16'h0000, 16'd2),
         row_lookup(21'hA0, 1'b1, 16'h0000),          // negative array index
         row_register(cmap4_pkg::CSR_SEGMENT_COUNT, 13'd0),
         row_lookup(21'h20, 1'b1, 16'h0000)           // table emptied again
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, register writes only with nothing in flight
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_table[i].is_csr) begin
            drain_lookups();
            write_reg(dir_table[i].reg_idx, dir_table[i].reg_val);
         end else begin
            it = dir_table[i].req;
            send_item(it, dir_table[i].typed, dir_table[i].glyph);
         end
      end

      // extremes of both counts, including values above the store depths
      run_phase(9'd1, 13'd0, 20);
      run_phase(9'd511, 13'd8191, 10);
      run_phase(9'd256, 13'd4096, 0);
      run_phase(9'd0, 13'd40, 40);

      // mostly small tables, now and then a large one
      while (n_items < ITEMS_TARGET - 150) begin
         nseg   = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(25, 511))
                                             : 9'($urandom_range(1, 24));
         nwords = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 8191))
                                             : 13'($urandom_range(0, 160));
         case ($urandom_range(0, 3))
            0:       gap = 0;
            1:       gap = 5;
            2:       gap = 20;
            default: gap = 50;
         endcase
         run_phase(nseg, nwords, gap);
      end

      // closing phase back to back, no idle cycles
      run_phase(9'($urandom_range(1, 24)), 13'($urandom_range(1, 160)), 0);
      drain_lookups();

      if (n_fail == 0) begin
         $display("** cmap_format4_glyph_lookup_core: PASSED **");
      end else begin
         $display("** cmap_format4_glyph_lookup_core: FAILED **");
      end
      $finish;
   end

endmodule
